FILE: hdl/bmsi_pkg.sv
`default_nettype none

package bmsi_pkg;

    // Function codes carried by each input word.
    localparam logic [1:0] FUNC_CPU_WRITE = 2'd0;
    localparam logic [1:0] FUNC_CPU_READ  = 2'd1;
    localparam logic [1:0] FUNC_PPU_BUS   = 2'd2;
    localparam logic [1:0] FUNC_CPU_ALT   = 2'd3;

    // CPU register regions, selected by addr[14:13] once addr[15] is set.
    localparam logic [1:0] REGION_BANK = 2'd0;
    localparam logic [1:0] REGION_MIRR = 2'd1;
    localparam logic [1:0] REGION_IRQ  = 2'd2;
    localparam logic [1:0] REGION_ENA  = 2'd3;

    // PRG slots, selected by addr[14:13].
    localparam logic [1:0] PRG_SLOT_LOW  = 2'd0;
    localparam logic [1:0] PRG_SLOT_MID  = 2'd1;
    localparam logic [1:0] PRG_SLOT_HIGH = 2'd2;
    localparam logic [1:0] PRG_SLOT_LAST = 2'd3;

    localparam int PRG_PAGE_W  = 6;
    localparam int CHR_PAGE_W  = 8;
    localparam int PRG_CFG_W   = 7;
    localparam int NUM_BANKS   = 8;
    localparam int BANK_IDX_W  = $clog2(NUM_BANKS);

    localparam logic [PRG_CFG_W-1:0] PRG_PAGES_RESET = 7'd32;

    // Register fields of bank select.
    localparam int SEL_PRG_SWAP_BIT = 6;
    localparam int SEL_CHR_INV_BIT  = 7;

    localparam logic [7:0] IRQ_COUNT_RELOAD = 8'hFF;

    // Mapping state as seen by the translation logic.
    typedef struct packed {
        logic [7:0]                 bank_select;
        logic [NUM_BANKS-1:0][7:0]  bank_regs;
        logic                       mirror_horizontal;
        logic                       irq_level;
    } map_state_t;

endpackage : bmsi_pkg

`default_nettype wire

FILE: hdl/bank_mapper_scanline_irq.sv
`default_nettype none

// Cartridge bank mapper with a scanline interrupt counter. Every input word
// (a CPU register write, a CPU read translate or a PPU bus address) yields
// exactly one output word holding the program, pattern and nametable pages
// for its address, computed with the mapping as it stands after that word,
// plus the current interrupt level. A word passes through an input register
// and then the output register, and the block takes one word every cycle for
// as long as the output side is not stalled; the loop through the mapper
// state registers sets that rate. The program page count register may be
// written only while no word is in flight.
module bank_mapper_scanline_irq
    import bmsi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_wr_en,
    input  wire logic [PRG_CFG_W-1:0]  cfg_wr_data,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            func,
    input  wire logic [15:0]           addr,
    input  wire logic [7:0]            data,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [PRG_PAGE_W-1:0]      prg_page,
    output logic [CHR_PAGE_W-1:0]      chr_page,
    output logic                       nt_page,
    output logic                       irq_out
);

    logic [PRG_CFG_W-1:0]  prg_pages_reg;

    // Input register.
    logic                  stg_valid_reg;
    logic [1:0]            stg_func_reg;
    logic [15:0]           stg_addr_reg;
    logic [7:0]            stg_data_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [PRG_PAGE_W-1:0] prg_page_reg;
    logic [CHR_PAGE_W-1:0] chr_page_reg;
    logic                  nt_page_reg;
    logic                  irq_out_reg;

    logic                  in_take;
    logic                  stg_adv;
    map_state_t            map_next;
    logic [PRG_PAGE_W-1:0] prg_page_next;
    logic [CHR_PAGE_W-1:0] chr_page_next;
    logic                  nt_page_next;

    // The staged word moves on whenever the output register is free or is
    // being emptied in the same cycle; that move is also when it updates
    // the mapper state.
    assign stg_adv  = stg_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = stg_valid_reg && !stg_adv;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prg_pages_reg <= PRG_PAGES_RESET;
        else if (cfg_wr_en)
            prg_pages_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (in_take)
            stg_valid_reg <= 1'b1;
        else if (stg_adv)
            stg_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stg_func_reg <= func;
            stg_addr_reg <= addr;
            stg_data_reg <= data;
        end
    end

    bmsi_state u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (stg_adv),
        .func     (stg_func_reg),
        .addr     (stg_addr_reg),
        .data     (stg_data_reg),
        .map_next (map_next)
    );

    // Translation uses the state after this word's own update.
    bmsi_xlate u_xlate (
        .map       (map_next),
        .addr      (stg_addr_reg),
        .prg_pages (prg_pages_reg),
        .prg_page  (prg_page_next),
        .chr_page  (chr_page_next),
        .nt_page   (nt_page_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stg_adv)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stg_adv)
        begin
            prg_page_reg <= prg_page_next;
            chr_page_reg <= chr_page_next;
            nt_page_reg  <= nt_page_next;
            irq_out_reg  <= map_next.irq_level;
        end
    end

    assign out_valid = out_valid_reg;
    assign prg_page  = prg_page_reg;
    assign chr_page  = chr_page_reg;
    assign nt_page   = nt_page_reg;
    assign irq_out   = irq_out_reg;

`ifndef SYNTHESIS
    // A word leaving the input register always lands in the output register.
    a_adv_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
        stg_adv |=> out_valid)
        else $error("staged word was not delivered to the output register");

    // A disable write must show the interrupt line low in its own result.
    a_disable_clears_irq : assert property (@(posedge clk) disable iff (!rst_n)
        (stg_adv && stg_func_reg == FUNC_CPU_WRITE && stg_addr_reg[15]
            && stg_addr_reg[14:13] == REGION_ENA && !stg_addr_reg[0])
        |=> !irq_out)
        else $error("interrupt still reported after a disable write");

    // The interrupt can only come up through a PPU bus word.
    a_irq_rise_from_ppu : assert property (@(posedge clk) disable iff (!rst_n)
        (stg_adv && !irq_out_reg && map_next.irq_level)
        |-> (stg_func_reg == FUNC_PPU_BUS))
        else $error("interrupt raised by a word that is not a PPU access");
`endif

endmodule : bank_mapper_scanline_irq

`default_nettype wire

FILE: hdl/bmsi_state.sv
`default_nettype none

module bmsi_state
    import bmsi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic [1:0]  func,
    input  wire logic [15:0] addr,
    input  wire logic [7:0]  data,
    output map_state_t       map_next
);

    map_state_t  map_reg;
    logic [7:0]  irq_latch_reg,  irq_latch_next;
    logic [7:0]  irq_count_reg,  irq_count_next;
    logic        irq_reload_reg, irq_reload_next;
    logic        irq_enable_reg, irq_enable_next;
    logic        prev_a12_reg,   prev_a12_next;

    logic        a12_edge;
    logic        count_zero;

    assign a12_edge   = !prev_a12_reg && addr[12];
    assign count_zero = (irq_count_reg == 8'd0);

    always_comb
    begin
        map_next        = map_reg;
        irq_latch_next  = irq_latch_reg;
        irq_count_next  = irq_count_reg;
        irq_reload_next = irq_reload_reg;
        irq_enable_next = irq_enable_reg;
        prev_a12_next   = prev_a12_reg;

        if (func == FUNC_CPU_WRITE && addr[15])
        begin
            unique case (addr[14:13])
                REGION_BANK:
                begin
                    if (addr[0])
                        map_next.bank_regs[map_reg.bank_select[BANK_IDX_W-1:0]] = data;
                    else
                        map_next.bank_select = data;
                end
                REGION_MIRR:
                begin
                    // The odd register (RAM protect) is not implemented.
                    if (!addr[0])
                        map_next.mirror_horizontal = data[0];
                end
                REGION_IRQ:
                begin
                    if (addr[0])
                    begin
                        irq_count_next  = IRQ_COUNT_RELOAD;
                        irq_reload_next = 1'b1;
                    end
                    else
                        irq_latch_next = data;
                end
                REGION_ENA:
                begin
                    if (addr[0])
                        irq_enable_next = 1'b1;
                    else
                    begin
                        irq_enable_next    = 1'b0;
                        map_next.irq_level = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (func == FUNC_PPU_BUS)
        begin
            prev_a12_next = addr[12];
            if (a12_edge)
            begin
                if (irq_reload_reg || count_zero)
                begin
                    if (irq_enable_reg && count_zero)
                        map_next.irq_level = 1'b1;
                    irq_count_next  = irq_latch_reg - 8'd1;
                    irq_reload_next = 1'b0;
                end
                else
                    irq_count_next = irq_count_reg - 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg        <= '0;
            irq_latch_reg  <= 8'd0;
            irq_count_reg  <= 8'd0;
            irq_reload_reg <= 1'b0;
            irq_enable_reg <= 1'b0;
            prev_a12_reg   <= 1'b0;
        end
        else if (en)
        begin
            map_reg        <= map_next;
            irq_latch_reg  <= irq_latch_next;
            irq_count_reg  <= irq_count_next;
            irq_reload_reg <= irq_reload_next;
            irq_enable_reg <= irq_enable_next;
            prev_a12_reg   <= prev_a12_next;
        end
    end

endmodule : bmsi_state

`default_nettype wire

FILE: hdl/bmsi_xlate.sv
`default_nettype none

module bmsi_xlate
    import bmsi_pkg::*;
(
    input  wire map_state_t              map,
    input  wire logic [15:0]             addr,
    input  wire logic [PRG_CFG_W-1:0]    prg_pages,
    output logic [PRG_PAGE_W-1:0]        prg_page,
    output logic [CHR_PAGE_W-1:0]        chr_page,
    output logic                         nt_page
);

    logic [PRG_PAGE_W-1:0] last_page;
    logic [PRG_PAGE_W-1:0] second_page;
    logic [PRG_PAGE_W-1:0] swap_page;
    logic                  prg_swap;
    logic [2:0]            chr_slot;
    logic [BANK_IDX_W-1:0] chr_idx;

    // Fixed pages wrap modulo 64, as the page field is six bits wide.
    assign last_page   = prg_pages[PRG_PAGE_W-1:0] - PRG_PAGE_W'(1);
    assign second_page = prg_pages[PRG_PAGE_W-1:0] - PRG_PAGE_W'(2);
    assign swap_page   = map.bank_regs[6][PRG_PAGE_W-1:0];
    assign prg_swap    = map.bank_select[SEL_PRG_SWAP_BIT];

    always_comb
    begin
        case (addr[14:13])
            PRG_SLOT_LOW:  prg_page = prg_swap ? second_page : swap_page;
            PRG_SLOT_MID:  prg_page = map.bank_regs[7][PRG_PAGE_W-1:0];
            PRG_SLOT_HIGH: prg_page = prg_swap ? swap_page : second_page;
            default:       prg_page = last_page;
        endcase
    end

    assign chr_slot = addr[12:10] ^ {map.bank_select[SEL_CHR_INV_BIT], 2'b00};
    assign chr_idx  = BANK_IDX_W'({1'b0, chr_slot[1:0]} + 3'd2);

    always_comb
    begin
        case (chr_slot)
            3'd0:    chr_page = {map.bank_regs[0][7:1], 1'b0};
            3'd1:    chr_page = {map.bank_regs[0][7:1], 1'b1};
            3'd2:    chr_page = {map.bank_regs[1][7:1], 1'b0};
            3'd3:    chr_page = {map.bank_regs[1][7:1], 1'b1};
            default: chr_page = map.bank_regs[chr_idx];
        endcase
    end

    assign nt_page = map.mirror_horizontal ? addr[11] : addr[10];

endmodule : bmsi_xlate

`default_nettype wire
